[rtl/shifted_dbcs_to_utf8_assert.svh]
// Assertion macros used by the top design file.
`ifndef SHIFTED_DBCS_TO_UTF8_ASSERT_SVH
`define SHIFTED_DBCS_TO_UTF8_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/sdu_pkg.sv]
package sdu_pkg;

  localparam int TABLE_DEPTH = 8192;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] MODE_DATA  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [0:0] CFG_TABLE_ENTRIES = 1'b0;
  localparam logic [0:0] CFG_DIRECTION     = 1'b1;

  localparam logic [7:0] SO_BYTE = 8'h0E;
  localparam logic [7:0] SI_BYTE = 8'h0F;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] addr;
    logic [31:0]       left;
    logic [31:0]       right;
  } tbl_wr_t;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic [1:0] cnt;
    logic       unm;
  } emit_t;

endpackage

[rtl/sdu_in_if.sv]
interface sdu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  in_byte;
  logic [12:0] entry_index;
  logic [31:0] entry_left;
  logic [31:0] entry_right;

  modport source (output valid, mode, in_byte, entry_index, entry_left, entry_right,
                  input ready);
  modport sink (input valid, mode, in_byte, entry_index, entry_left, entry_right,
                output ready);
endinterface

[rtl/sdu_out_if.sv]
interface sdu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;
  logic       unmapped;

  modport source (output valid, out_byte, last_byte, unmapped, input ready);
  modport sink (input valid, out_byte, last_byte, unmapped, output ready);
endinterface

[rtl/sdu_table.sv]
module sdu_table (
  input  logic                    clk,
  input  sdu_pkg::tbl_wr_t        wr,
  input  logic [sdu_pkg::ADDR_W-1:0] rd_addr,
  output logic [31:0]             rd_left,
  output logic [31:0]             rd_right
);
  import sdu_pkg::*;

  logic [31:0] left_mem  [TABLE_DEPTH];
  logic [31:0] right_mem [TABLE_DEPTH];
  logic [31:0] rd_left_r;
  logic [31:0] rd_right_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      left_mem[wr.addr]  <= wr.left;
      right_mem[wr.addr] <= wr.right;
    end
  end

  always_ff @(posedge clk) begin
    rd_left_r  <= left_mem[rd_addr];
    rd_right_r <= right_mem[rd_addr];
  end

  assign rd_left  = rd_left_r;
  assign rd_right = rd_right_r;

endmodule

[rtl/shifted_dbcs_to_utf8.sv]
// Channel  Role     Beat carries
// in_if    sink     mode, in_byte, entry_index, entry_left, entry_right
// out_if   source   out_byte, last_byte, unmapped
// cfg_*    write    cfg_index selects the register, cfg_data the value
//
// Table writes, shift bytes, first bytes of a pair and state clears stay in ST_IDLE.
// A character is an input beat, then p table probes, at most 14 for 8192 entries,
// one a cycle through the single read port of the table, then 1 to 3 byte beats.
// Reset sets direction to 1, clears shift, pairing and entry count, not the table.
// While out_if.ready is low the current byte holds and no new beat is taken.
module shifted_dbcs_to_utf8 (
  input  logic       clk,
  input  logic       rst_n,
  sdu_in_if.sink     in_if,
  sdu_out_if.source  out_if,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [13:0] cfg_data
);
  import sdu_pkg::*;

  `include "shifted_dbcs_to_utf8_assert.svh"

  state_t            state_r, state_nxt;
  logic [13:0]       entries_r;
  logic              direction_r;
  logic              shifted_r, shifted_nxt;
  logic              await_r, await_nxt;
  logic [7:0]        held_r, held_nxt;
  logic [15:0]       code_r, code_nxt;
  logic [CNT_W-1:0]  lo_r, lo_nxt;
  logic [CNT_W-1:0]  hi1_r, hi1_nxt;
  logic [ADDR_W-1:0] mid_r, mid_nxt;
  emit_t             emit_r, emit_nxt;

  tbl_wr_t           wr;
  logic [31:0]       rd_left, rd_right;
  logic [31:0]       key_w, val_w;
  logic [CNT_W-1:0]  n_w, lo_c, hi1_c;
  logic [CNT_W:0]    sum_w;
  logic              start_w;
  logic              beat_in, beat_out;

  function automatic emit_t encode(input logic found, input logic [31:0] v);
    emit_t e;
    e = '{b0: 8'hEF, b1: 8'hBF, b2: 8'hBD, cnt: 2'd3, unm: 1'b1};
    if (found && v <= 32'h07F) begin
      e = '{b0: v[7:0], b1: 8'h00, b2: 8'h00, cnt: 2'd1, unm: 1'b0};
    end else if (found && v <= 32'h07FF) begin
      e = '{b0: 8'hC0 | {3'b000, v[10:6]}, b1: 8'h80 | {2'b00, v[5:0]},
            b2: 8'h00, cnt: 2'd2, unm: 1'b0};
    end else if (found && v <= 32'hFFFF) begin
      e = '{b0: 8'hE0 | {4'b0000, v[15:12]}, b1: 8'h80 | {2'b00, v[11:6]},
            b2: 8'h80 | {2'b00, v[5:0]}, cnt: 2'd3, unm: 1'b0};
    end
    return e;
  endfunction

  sdu_table u_table (
    .clk      (clk),
    .wr       (wr),
    .rd_addr  (mid_nxt),
    .rd_left  (rd_left),
    .rd_right (rd_right)
  );

  assign beat_in  = in_if.valid && in_if.ready;
  assign beat_out = out_if.valid && out_if.ready;

  assign n_w   = (32'(entries_r) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(entries_r);
  assign key_w = direction_r ? rd_left : rd_right;
  assign val_w = direction_r ? rd_right : rd_left;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r   <= '0;
      direction_r <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TABLE_ENTRIES: entries_r   <= cfg_data;
        CFG_DIRECTION:     direction_r <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      shifted_r <= 1'b0;
      await_r   <= 1'b0;
      held_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      shifted_r <= shifted_nxt;
      await_r   <= await_nxt;
      held_r    <= held_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
    lo_r   <= lo_nxt;
    hi1_r  <= hi1_nxt;
    mid_r  <= mid_nxt;
    emit_r <= emit_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    shifted_nxt = shifted_r;
    await_nxt   = await_r;
    held_nxt    = held_r;
    code_nxt    = code_r;
    lo_nxt      = lo_r;
    hi1_nxt     = hi1_r;
    emit_nxt    = emit_r;
    start_w     = 1'b0;
    lo_c        = lo_r;
    hi1_c       = hi1_r;
    wr          = '{we: 1'b0, addr: ADDR_W'(in_if.entry_index),
                    left: in_if.entry_left, right: in_if.entry_right};

    case (state_r)
      ST_IDLE: begin
        lo_c  = '0;
        hi1_c = n_w;
        if (beat_in) begin
          case (in_if.mode)
            MODE_WRITE: begin
              wr.we = 32'(in_if.entry_index) < TABLE_DEPTH;
            end
            MODE_CLEAR: begin
              shifted_nxt = 1'b0;
              await_nxt   = 1'b0;
            end
            MODE_DATA: begin
              if (in_if.in_byte == SO_BYTE && !shifted_r) begin
                shifted_nxt = 1'b1;
              end else if (in_if.in_byte == SI_BYTE && shifted_r) begin
                shifted_nxt = 1'b0;
              end else if (await_r) begin
                await_nxt = 1'b0;
                code_nxt  = {held_r, in_if.in_byte};
                start_w   = 1'b1;
              end else if (!shifted_r) begin
                code_nxt = {8'h00, in_if.in_byte};
                start_w  = 1'b1;
              end else begin
                held_nxt  = in_if.in_byte;
                await_nxt = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_PROBE: begin
        if (key_w == {16'h0000, code_r}) begin
          emit_nxt  = encode(1'b1, val_w);
          state_nxt = ST_EMIT;
        end else begin
          if ({16'h0000, code_r} < key_w) begin
            hi1_c = CNT_W'(mid_r);
          end else begin
            lo_c = CNT_W'(mid_r) + CNT_W'(1);
          end
          start_w = 1'b1;
        end
      end
      ST_EMIT: begin
        if (beat_out) begin
          emit_nxt.b0  = emit_r.b1;
          emit_nxt.b1  = emit_r.b2;
          emit_nxt.cnt = emit_r.cnt - 2'd1;
          if (emit_r.cnt == 2'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    sum_w   = {1'b0, lo_c} + {1'b0, hi1_c} - (CNT_W + 1)'(1);
    mid_nxt = ADDR_W'(sum_w >> 1);

    if (start_w) begin
      lo_nxt  = lo_c;
      hi1_nxt = hi1_c;
      if (lo_c < hi1_c) begin
        state_nxt = ST_PROBE;
      end else begin
        emit_nxt  = encode(1'b0, 32'h0);
        state_nxt = ST_EMIT;
      end
    end
  end

  assign in_if.ready      = (state_r == ST_IDLE);
  assign out_if.valid     = (state_r == ST_EMIT);
  assign out_if.out_byte  = emit_r.b0;
  assign out_if.last_byte = (emit_r.cnt == 2'd1);
  assign out_if.unmapped  = emit_r.unm;

  `SDU_ASSERT_NOW(a_one_side, out_if.valid, !in_if.ready, "input taken while a byte waits")
  `SDU_ASSERT_NEXT(a_last_ends, beat_out && out_if.last_byte, !out_if.valid, "byte after last")
  `SDU_ASSERT_NOW(a_repl_tail, out_if.valid && out_if.unmapped && out_if.last_byte,
                  out_if.out_byte == 8'hBD, "bad replacement tail")
  `SDU_ASSERT_NOW(a_probe_range, state_r == ST_PROBE, lo_r < hi1_r, "probe on empty range")

endmodule
